>>> sv/double_hash_table_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
// Each macro expects clk and rst_n in scope.
`ifndef DOUBLE_HASH_TABLE_MACROS_SVH
`define DOUBLE_HASH_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
`define DHT_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define DHT_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define DHT_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define DHT_ASSERT(lbl, expr, msg)
`define DHT_ASSERT_IMP(lbl, pre, post, msg)
`define DHT_ASSERT_NXT(lbl, pre, post, msg)
`endif

`endif

>>> sv/dht_pkg.sv
`timescale 1ns / 1ps

package dht_pkg;

  // default configuration
  localparam int TABLE_SLOTS_DEF  = 10;
  localparam int STEP_MODULUS_DEF = 7;
  localparam int KEY_CHARS_DEF    = 4;

  // key characters live in a 32-bit word, so the weighted sum is at most
  // 255 * (1 + 7 + 49 + 343) = 102000
  localparam int KEY_BYTES  = 4;
  localparam int HASH_BASE  = 7;
  localparam int KEY_VAL_W  = 17;
  localparam int KEY_WORD_W = 3 + 8 * KEY_BYTES;  // length + masked chars
  localparam int PAYLOAD_W  = 32;

  // digit width of the mod reduction unit
  localparam int NIB_W = 4;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  // result codes
  localparam logic [1:0] RES_DONE     = 2'd0;
  localparam logic [1:0] RES_FULL     = 2'd1;
  localparam logic [1:0] RES_NOTFOUND = 2'd2;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_OCC   = 2'd1,
    ST_DEL   = 2'd2
  } slot_st_t;

endpackage

>>> sv/double_hash_table.sv
`timescale 1ns / 1ps
// Requests are handled one at a time: in_stall is high from a transfer until
//   its result is handed to the output register; an unused op skips hashing.
// Time per request is set by the serial hash and mod digits and one slot
//   probe per cycle, so it grows with key length and slots probed.
// Reset: synchronous, active low; slot status clears to empty at once,
//   the key/payload RAM is not cleared.

module double_hash_table #(
  parameter int TABLE_SLOTS  = dht_pkg::TABLE_SLOTS_DEF,
  parameter int STEP_MODULUS = dht_pkg::STEP_MODULUS_DEF,
  parameter int KEY_CHARS    = dht_pkg::KEY_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_key_bytes,
  input  logic [2:0]  in_key_length,
  input  logic [31:0] in_entry_payload,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_code,
  output logic [3:0]  out_slot_index,
  output logic [31:0] out_found_payload
);

  `include "double_hash_table_macros.svh"

  // slot index and step residue widths
  localparam int HW    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int SMW   = (STEP_MODULUS > 1) ? $clog2(STEP_MODULUS) : 1;
  // probe increment 1 + (key mod STEP_MODULUS) is at most STEP_MODULUS
  localparam int INC_W = SMW + 1;

  localparam int NIB_W    = dht_pkg::NIB_W;
  localparam int KVW      = dht_pkg::KEY_VAL_W;
  localparam int KWW      = dht_pkg::KEY_WORD_W;
  localparam int PW       = dht_pkg::PAYLOAD_W;
  localparam int ENTRY_W  = KWW + PW;
  localparam int KEY_NIBS = (KVW + NIB_W - 1) / NIB_W;
  localparam int INC_NIBS = (INC_W + NIB_W - 1) / NIB_W;
  localparam int SH_W     = KEY_NIBS * NIB_W;
  localparam int CNT_W    = (KEY_NIBS > 1) ? $clog2(KEY_NIBS) : 1;

  localparam logic [KVW-1:0] BASE_V  = KVW'(dht_pkg::HASH_BASE);
  localparam logic [HW:0]    SLOTS_V = (HW+1)'(TABLE_SLOTS);

  // Sequencer:
  //   IDLE   - take a request, latch key word and payload
  //   HORNER - key value, one character per cycle, leftmost first
  //   MODK   - key mod TABLE_SLOTS and key mod STEP_MODULUS, one digit/cycle
  //   MODI   - probe increment mod TABLE_SLOTS on the same unit
  //   CHK    - one slot per cycle; next slot's RAM read issued alongside
  //   RESULT - hand the result to the output register
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_HORNER = 6'b000010,
    S_MODK   = 6'b000100,
    S_MODI   = 6'b001000,
    S_CHK    = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]      req_r, req_nxt;
  logic [KWW-1:0]  kw_r, kw_nxt;
  logic [PW-1:0]   pay_r, pay_nxt;
  logic [31:0]     bytes_r, bytes_nxt;
  logic [1:0]      pos_r, pos_nxt;
  logic [KVW-1:0]  acc_r, acc_nxt;
  logic [SH_W-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [HW-1:0]   ra_r, ra_nxt;
  logic [SMW-1:0]  rb_r, rb_nxt;
  logic [HW-1:0]   home_r, home_nxt;
  logic [HW-1:0]   step_r, step_nxt;
  logic [HW-1:0]   p_r, p_nxt;
  logic [1:0]      res_code_r, res_code_nxt;
  logic [HW-1:0]   res_idx_r, res_idx_nxt;
  logic [PW-1:0]   res_pay_r, res_pay_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            out_load;
  logic [1:0]      out_code_r;
  logic [3:0]      out_idx_r;
  logic [PW-1:0]   out_pay_r;

  dht_pkg::slot_st_t status_r [TABLE_SLOTS];
  dht_pkg::slot_st_t cur_st;
  dht_pkg::slot_st_t st_val;
  logic              st_we;

  // request decode
  logic            in_xfer;
  logic [2:0]      len_eff;
  logic [2:0]      nch;
  logic [31:0]     key_mask;

  // hashing datapath
  logic [7:0]      cur_char;
  logic [KVW-1:0]  horner_val;
  logic [HW-1:0]   ra_step;
  logic [SMW-1:0]  rb_step;
  logic [INC_W-1:0] inc_v;

  // probe datapath
  logic [HW:0]     slot_sum;
  logic [HW-1:0]   p_next;
  logic            wrap;
  logic            key_hit;
  logic [KWW-1:0]  rd_key;
  logic [PW-1:0]   rd_pay;

  // key/payload RAM port
  logic               ram_we;
  logic [HW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // Lengths past KEY_CHARS saturate; only the four bytes carry characters.
  assign len_eff  = (32'(in_key_length) > KEY_CHARS) ? 3'(KEY_CHARS) : in_key_length;
  assign nch      = (len_eff >= 3'(dht_pkg::KEY_BYTES)) ? 3'(dht_pkg::KEY_BYTES) : len_eff;
  assign key_mask = (len_eff >= 3'(dht_pkg::KEY_BYTES)) ? '1 :
                    ((32'd1 << {len_eff[1:0], 3'b000}) - 32'd1);

  // Horner step: acc * 7 + char at the current position
  assign cur_char   = bytes_r[{pos_r, 3'b000} +: 8];
  assign horner_val = acc_r * BASE_V + KVW'(cur_char);

  // Shared reduction unit. Lane A runs mod TABLE_SLOTS, lane B mod
  // STEP_MODULUS; digits come from the top of the shift register.
  dht_mod_unit #(
    .MOD_A (TABLE_SLOTS),
    .MOD_B (STEP_MODULUS)
  ) u_mod (
    .nib_i (sh_r[SH_W-1 -: NIB_W]),
    .ra_i  (ra_r),
    .rb_i  (rb_r),
    .ra_o  (ra_step),
    .rb_o  (rb_step)
  );

  assign inc_v = INC_W'(rb_step) + INC_W'(1);

  // both p_r and step_r are below TABLE_SLOTS, so one subtract wraps
  assign slot_sum = {1'b0, p_r} + {1'b0, step_r};
  assign p_next   = (slot_sum >= SLOTS_V) ? HW'(slot_sum - SLOTS_V) : HW'(slot_sum);
  assign wrap     = (p_next == home_r);

  assign rd_key  = ram_rdata[ENTRY_W-1 -: KWW];
  assign rd_pay  = ram_rdata[PW-1:0];
  assign key_hit = (rd_key == kw_r);
  assign cur_st  = status_r[p_r];

  // The RAM read is registered, so its address runs ahead: home slot while
  // reducing, then the next slot on the probe path while checking the current one.
  assign ram_raddr = (state_r == S_CHK) ? p_next : home_r;

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    kw_nxt       = kw_r;
    pay_nxt      = pay_r;
    bytes_nxt    = bytes_r;
    pos_nxt      = pos_r;
    acc_nxt      = acc_r;
    sh_nxt       = sh_r;
    cnt_nxt      = cnt_r;
    ra_nxt       = ra_r;
    rb_nxt       = rb_r;
    home_nxt     = home_r;
    step_nxt     = step_r;
    p_nxt        = p_r;
    res_code_nxt = res_code_r;
    res_idx_nxt  = res_idx_r;
    res_pay_nxt  = res_pay_r;
    ram_we       = 1'b0;
    st_we        = 1'b0;
    st_val       = dht_pkg::ST_OCC;
    out_load     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          req_nxt      = in_req_type;
          kw_nxt       = {len_eff, in_key_bytes & key_mask};
          pay_nxt      = in_entry_payload;
          bytes_nxt    = in_key_bytes;
          acc_nxt      = '0;
          pos_nxt      = 2'(nch - 3'd1);
          res_code_nxt = dht_pkg::RES_NOTFOUND;
          res_idx_nxt  = '0;
          res_pay_nxt  = '0;
          sh_nxt       = '0;
          ra_nxt       = '0;
          rb_nxt       = '0;
          cnt_nxt      = CNT_W'(KEY_NIBS - 1);
          if (!(in_req_type inside {dht_pkg::REQ_INSERT, dht_pkg::REQ_SEARCH,
                                    dht_pkg::REQ_DELETE})) begin
            // unused operation: not found, table untouched
            state_nxt = S_RESULT;
          end else if (nch == 3'd0) begin
            // empty key hashes as value zero
            state_nxt = S_MODK;
          end else begin
            state_nxt = S_HORNER;
          end
        end
      end

      S_HORNER: begin
        acc_nxt = horner_val;
        if (pos_r == 2'd0) begin
          sh_nxt    = SH_W'(horner_val);
          ra_nxt    = '0;
          rb_nxt    = '0;
          cnt_nxt   = CNT_W'(KEY_NIBS - 1);
          state_nxt = S_MODK;
        end else begin
          pos_nxt = pos_r - 2'd1;
        end
      end

      S_MODK: begin
        ra_nxt  = ra_step;
        rb_nxt  = rb_step;
        sh_nxt  = sh_r << NIB_W;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          // home slot done; reduce the increment on lane A next
          home_nxt  = ra_step;
          ra_nxt    = '0;
          sh_nxt    = SH_W'(inc_v) << (SH_W - INC_NIBS * NIB_W);
          cnt_nxt   = CNT_W'(INC_NIBS - 1);
          state_nxt = S_MODI;
        end
      end

      S_MODI: begin
        ra_nxt  = ra_step;
        sh_nxt  = sh_r << NIB_W;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          step_nxt  = ra_step;
          p_nxt     = home_r;
          state_nxt = S_CHK;
        end
      end

      S_CHK: begin
        p_nxt = p_next;
        if (req_r == dht_pkg::REQ_INSERT) begin
          if (cur_st != dht_pkg::ST_OCC) begin
            // first empty or deleted slot takes the entry
            ram_we       = 1'b1;
            st_we        = 1'b1;
            st_val       = dht_pkg::ST_OCC;
            res_code_nxt = dht_pkg::RES_DONE;
            res_idx_nxt  = p_r;
            state_nxt    = S_RESULT;
          end else if (wrap) begin
            res_code_nxt = dht_pkg::RES_FULL;
            state_nxt    = S_RESULT;
          end
        end else begin
          if (cur_st != dht_pkg::ST_OCC && cur_st != dht_pkg::ST_DEL) begin
            // empty slot ends the chain
            state_nxt = S_RESULT;
          end else if (key_hit) begin
            // a deleted slot with the same key also ends the search
            if (cur_st == dht_pkg::ST_OCC) begin
              res_code_nxt = dht_pkg::RES_DONE;
              res_idx_nxt  = p_r;
              if (req_r == dht_pkg::REQ_SEARCH) begin
                res_pay_nxt = rd_pay;
              end else begin
                st_we  = 1'b1;
                st_val = dht_pkg::ST_DEL;
              end
            end
            state_nxt = S_RESULT;
          end else if (wrap) begin
            state_nxt = S_RESULT;
          end
        end
      end

      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  dht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p_r),
    .wdata ({kw_r, pay_r}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        status_r[i] <= dht_pkg::ST_EMPTY;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (st_we) begin
        status_r[p_r] <= st_val;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    kw_r       <= kw_nxt;
    pay_r      <= pay_nxt;
    bytes_r    <= bytes_nxt;
    pos_r      <= pos_nxt;
    acc_r      <= acc_nxt;
    sh_r       <= sh_nxt;
    cnt_r      <= cnt_nxt;
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    home_r     <= home_nxt;
    step_r     <= step_nxt;
    p_r        <= p_nxt;
    res_code_r <= res_code_nxt;
    res_idx_r  <= res_idx_nxt;
    res_pay_r  <= res_pay_nxt;
    if (out_load) begin
      out_code_r <= res_code_r;
      out_idx_r  <= 4'(res_idx_r);
      out_pay_r  <= res_pay_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_code   = out_code_r;
  assign out_slot_index    = out_idx_r;
  assign out_found_payload = out_pay_r;

  `DHT_ASSERT_IMP(a_probe_range, state_r == S_CHK,
                  p_r < TABLE_SLOTS && step_r < TABLE_SLOTS,
                  "probe slot or step out of range")
  `DHT_ASSERT_NXT(a_insert_marks, ram_we,
                  status_r[$past(p_r)] == dht_pkg::ST_OCC,
                  "inserted slot not occupied")
  `DHT_ASSERT_NXT(a_delete_marks, st_we && st_val == dht_pkg::ST_DEL,
                  status_r[$past(p_r)] == dht_pkg::ST_DEL,
                  "deleted slot not marked")
  `DHT_ASSERT_NXT(a_result_holds, state_r == S_RESULT && out_valid_r && out_stall,
                  state_r == S_RESULT,
                  "result left while output busy")

endmodule

>>> sv/dht_ram.sv
`timescale 1ns / 1ps

module dht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/dht_mod_unit.sv
`timescale 1ns / 1ps

// Two-lane restoring remainder step: folds one digit (MSB first) into
// running residues modulo MOD_A and MOD_B.
module dht_mod_unit #(
  parameter int MOD_A = 10,
  parameter int MOD_B = 7,
  localparam int AW = (MOD_A > 1) ? $clog2(MOD_A) : 1,
  localparam int BW = (MOD_B > 1) ? $clog2(MOD_B) : 1
) (
  input  logic [dht_pkg::NIB_W-1:0] nib_i,
  input  logic [AW-1:0]             ra_i,
  input  logic [BW-1:0]             rb_i,
  output logic [AW-1:0]             ra_o,
  output logic [BW-1:0]             rb_o
);

  localparam logic [AW:0] MA = (AW+1)'(MOD_A);
  localparam logic [BW:0] MB = (BW+1)'(MOD_B);

  logic [AW-1:0] a;
  logic [BW-1:0] b;
  logic [AW:0]   ta;
  logic [BW:0]   tb;

  always_comb begin
    a  = ra_i;
    b  = rb_i;
    ta = '0;
    tb = '0;
    for (int k = dht_pkg::NIB_W - 1; k >= 0; k--) begin
      ta = {a, nib_i[k]};
      if (ta >= MA) begin
        ta = ta - MA;
      end
      a  = ta[AW-1:0];
      tb = {b, nib_i[k]};
      if (tb >= MB) begin
        tb = tb - MB;
      end
      b  = tb[BW-1:0];
    end
    ra_o = a;
    rb_o = b;
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  // Table geometry as built into the block under test
  localparam int SLOTS     = dht_pkg::TABLE_SLOTS_DEF;
  localparam int STEP_MOD  = dht_pkg::STEP_MODULUS_DEF;
  localparam int MAX_CHARS = dht_pkg::KEY_CHARS_DEF;

  // req_type 3 has no operation behind it; it must answer "not found"
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1230;
  localparam int POOL_KEYS    = 8;    // small pool so keys repeat and collide
  localparam int POOL_REFRESH = 150;  // requests between new key pools
  localparam int IDLE_PCT     = 22;
  localparam int CALM_LO      = 500;  // transfer window with no idling
  localparam int CALM_HI      = 700;
  localparam int HOLD_AT      = 300;  // results seen before the long hold
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] kbytes;
    logic [2:0]  klen;
    logic [31:0] pay;
  } dht_req_t;

  typedef struct packed {
    logic [1:0]  code;
    logic [3:0]  slot;
    logic [31:0] pay;
  } dht_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = '0;
  logic [31:0] in_key_bytes = '0;
  logic [2:0]  in_key_length = '0;
  logic [31:0] in_entry_payload = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_code;
  logic [3:0]  out_slot_index;
  logic [31:0] out_found_payload;

  double_hash_table dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_key_bytes      (in_key_bytes),
    .in_key_length     (in_key_length),
    .in_entry_payload  (in_entry_payload),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_code   (out_result_code),
    .out_slot_index    (out_slot_index),
    .out_found_payload (out_found_payload)
  );

  always #10 clk = ~clk;

  // Shadow of the table contents; status starts empty, keys/payloads are
  // only read for slots that were written.
  dht_pkg::slot_st_t tbl_st  [SLOTS];
  logic [34:0]       tbl_key [SLOTS];
  logic [31:0]       tbl_pay [SLOTS];

  dht_req_t req_backlog[$];   // requests not yet offered to the block
  dht_res_t due_results[$];   // answers owed, oldest first
  dht_req_t next_req;

  int  req_total;
  int  reqs_taken;
  int  results_seen;
  int  errors;
  int  cycles;
  int  op_tally  [4];
  int  code_tally[4];
  int  hold_left;
  bit  hold_done;
  bit  in_fire;

  initial begin
    foreach (tbl_st[i]) tbl_st[i] = dht_pkg::ST_EMPTY;
  end

  function automatic int step_slot(int p, int kv);
    return (p + 1 + kv % STEP_MOD) % SLOTS;
  endfunction

  // Walk the probe path for a live copy of the key. A deleted slot that
  // holds the same key ends the walk: later duplicates are shadowed.
  function automatic bit find_live(logic [34:0] kw, int kv, output int slot);
    int home;
    int p;
    home = kv % SLOTS;
    p = home;
    slot = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (tbl_st[p] == dht_pkg::ST_EMPTY) return 1'b0;
      if (tbl_key[p] == kw) begin
        if (tbl_st[p] == dht_pkg::ST_OCC) begin
          slot = p;
          return 1'b1;
        end
        return 1'b0;
      end
      p = step_slot(p, kv);
      if (p == home) return 1'b0;
    end
    return 1'b0;
  endfunction

  // Apply one request to the shadow table and return the answer it earns.
  function automatic dht_res_t run_table_op(dht_req_t r);
    dht_res_t    res;
    logic [2:0]  len;
    logic [31:0] mask;
    logic [34:0] kw;
    int          kv;
    int          w;
    int          home;
    int          p;
    int          hit;
    res = '{code: dht_pkg::RES_NOTFOUND, slot: 4'd0, pay: 32'd0};
    // lengths past the key width saturate; bytes outside the key don't count
    len  = (r.klen > MAX_CHARS) ? 3'(MAX_CHARS) : r.klen;
    mask = (len >= dht_pkg::KEY_BYTES) ? '1 : ((32'd1 << (8 * len)) - 32'd1);
    kw   = {len, r.kbytes & mask};
    kv = 0;
    w  = 1;
    for (int i = 0; i < len; i++) begin
      kv += int'(r.kbytes[8*i +: 8]) * w;
      w  *= dht_pkg::HASH_BASE;
    end
    home = kv % SLOTS;
    case (r.op)
      dht_pkg::REQ_INSERT: begin
        // first empty or deleted slot on the path; no duplicate check
        res.code = dht_pkg::RES_FULL;
        p = home;
        for (int n = 0; n < SLOTS; n++) begin
          if (tbl_st[p] != dht_pkg::ST_OCC) begin
            tbl_st[p]  = dht_pkg::ST_OCC;
            tbl_key[p] = kw;
            tbl_pay[p] = r.pay;
            res.code   = dht_pkg::RES_DONE;
            res.slot   = 4'(p);
            break;
          end
          p = step_slot(p, kv);
          if (p == home) break;
        end
      end
      dht_pkg::REQ_SEARCH: begin
        if (find_live(kw, kv, hit)) begin
          res.code = dht_pkg::RES_DONE;
          res.slot = 4'(hit);
          res.pay  = tbl_pay[hit];
        end
      end
      dht_pkg::REQ_DELETE: begin
        if (find_live(kw, kv, hit)) begin
          tbl_st[hit] = dht_pkg::ST_DEL;
          res.code    = dht_pkg::RES_DONE;
          res.slot    = 4'(hit);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Random idling, switched off inside the calm window of transfers.
  function automatic bit take_break(int done_cnt);
    if (done_cnt >= CALM_LO && done_cnt < CALM_HI) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  task automatic queue_req(logic [1:0] op, logic [31:0] kbytes, logic [2:0] klen,
                           logic [31:0] pay);
    req_backlog.push_back('{op: op, kbytes: kbytes, klen: klen, pay: pay});
  endtask

  // Request side: a transfer is taken at the rising edge; the expected
  // answer is worked out right there, in transfer order.
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      due_results.push_back(run_table_op('{op: in_req_type, kbytes: in_key_bytes,
                                           klen: in_key_length, pay: in_entry_payload}));
      op_tally[in_req_type]++;
      reqs_taken++;
    end
  end

  // Driver: offers the next request at the falling edge once the previous
  // one has gone across, or idles at random. valid is set exactly
  // once per step, and a stalled request is left alone.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (req_backlog.size() != 0 && !take_break(reqs_taken)) begin
        next_req = req_backlog.pop_front();
        in_req_type      <= next_req.op;
        in_key_bytes     <= next_req.kbytes;
        in_key_length    <= next_req.klen;
        in_entry_payload <= next_req.pay;
        in_valid         <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stall: random, plus one long hold partway through so the
  // block backs up and stalls its request port.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= take_break(results_seen);
    end
  end

  // Monitor: every result transfer is checked against the oldest answer owed.
  always @(posedge clk) begin
    dht_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $display("%0t: result with none expected: code %0d slot %0d payload %h",
                 $time, out_result_code, out_slot_index, out_found_payload);
        errors++;
      end else begin
        want = due_results.pop_front();
        code_tally[want.code]++;
        if (out_result_code !== want.code) begin
          $display("%0t: result_code expected %0d, got %0d",
                   $time, want.code, out_result_code);
          errors++;
        end
        if (out_slot_index !== want.slot) begin
          $display("%0t: slot_index expected %0d, got %0d",
                   $time, want.slot, out_slot_index);
          errors++;
        end
        if (out_found_payload !== want.pay) begin
          $display("%0t: found_payload expected %h, got %h",
                   $time, want.pay, out_found_payload);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d of %0d requests taken, %0d answers owed",
               $time, reqs_taken, req_total, due_results.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] pool_bytes[POOL_KEYS];
    logic [2:0]  pool_len  [POOL_KEYS];
    logic [31:0] kbytes;
    logic [31:0] mask;
    logic [2:0]  klen;
    logic [1:0]  op;
    int          roll;
    int          pick;

    // --- directed part ---
    // lookup in an empty table, empty key
    queue_req(dht_pkg::REQ_SEARCH, 32'h0, 3'd0, 32'h0);
    // empty key is a real key (value 0, home slot 0)
    queue_req(dht_pkg::REQ_INSERT, 32'h0, 3'd0, 32'hFFFF_FFFF);
    // same empty key with junk in every byte must still match
    queue_req(dht_pkg::REQ_SEARCH, 32'hFFFF_FFFF, 3'd0, 32'h1234_5678);
    // one character, junk in the unused bytes
    queue_req(dht_pkg::REQ_INSERT, 32'hFFFF_FF41, 3'd1, 32'hA5A5_A5A5);
    // overlong length saturates to four characters; largest key value
    queue_req(dht_pkg::REQ_INSERT, 32'hFFFF_FFFF, 3'd7, 32'h0);
    queue_req(dht_pkg::REQ_SEARCH, 32'hFFFF_FFFF, 3'd4, 32'h0);
    // duplicate insert, delete marks the first copy, which then hides the
    // second one from search and delete
    queue_req(dht_pkg::REQ_INSERT, 32'h0063_6174, 3'd3, 32'h0000_0001);
    queue_req(dht_pkg::REQ_INSERT, 32'hEE63_6174, 3'd3, 32'h0000_0002);
    queue_req(dht_pkg::REQ_DELETE, 32'h0063_6174, 3'd3, 32'h0);
    queue_req(dht_pkg::REQ_SEARCH, 32'h0063_6174, 3'd3, 32'h0);
    queue_req(dht_pkg::REQ_DELETE, 32'h0063_6174, 3'd3, 32'h0);
    queue_req(REQ_UNUSED, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
    // empty keys step by one, so they fill every free slot (deleted one too)
    // and the last insert finds the table full
    for (int n = 0; n < 7; n++) queue_req(dht_pkg::REQ_INSERT, $urandom, 3'd0, $urandom);
    // miss on a full table: the probe wraps back home
    queue_req(dht_pkg::REQ_SEARCH, 32'h0000_7A7A, 3'd2, 32'h0);
    queue_req(dht_pkg::REQ_DELETE, 32'h0, 3'd0, 32'h0);

    // --- random part: keys mostly from a small pool, with junk bytes and
    // overlong lengths, plus some fresh keys ---
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % POOL_REFRESH == 0) begin
        for (int j = 0; j < POOL_KEYS; j++) begin
          pool_len[j]   = 3'($urandom_range(0, 4));
          pool_bytes[j] = $urandom;
        end
      end
      roll = $urandom_range(99);
      if (roll < 6)       op = REQ_UNUSED;
      else if (roll < 40) op = dht_pkg::REQ_INSERT;
      else if (roll < 70) op = dht_pkg::REQ_SEARCH;
      else                op = dht_pkg::REQ_DELETE;
      if ($urandom_range(9) == 0) begin
        klen   = 3'($urandom_range(0, 7));
        kbytes = $urandom;
      end else begin
        pick   = $urandom_range(POOL_KEYS - 1);
        klen   = pool_len[pick];
        mask   = (klen >= dht_pkg::KEY_BYTES) ? '1 : ((32'd1 << (8 * klen)) - 32'd1);
        kbytes = (pool_bytes[pick] & mask) | ($urandom & ~mask);
        if (klen == 3'(MAX_CHARS) && $urandom_range(3) == 0)
          klen = 3'($urandom_range(MAX_CHARS, 7));
      end
      queue_req(op, kbytes, klen, $urandom);
    end
    req_total = req_backlog.size();

    // reset: held, then released between edges
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // drain: every request taken and every answer back, then a quiet tail
    while (reqs_taken != req_total || due_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d requests: %0d insert, %0d search, %0d delete, %0d unused op",
             reqs_taken, op_tally[dht_pkg::REQ_INSERT], op_tally[dht_pkg::REQ_SEARCH],
             op_tally[dht_pkg::REQ_DELETE], op_tally[REQ_UNUSED]);
    $display("Answers: %0d done/found, %0d table full, %0d not found; %0d mismatches",
             code_tally[dht_pkg::RES_DONE], code_tally[dht_pkg::RES_FULL],
             code_tally[dht_pkg::RES_NOTFOUND], errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> double_hash_table.f
+incdir+sv
sv/dht_pkg.sv
sv/dht_ram.sv
sv/dht_mod_unit.sv
sv/double_hash_table.sv
tb/tb.sv
